/* rtl/core/first_substring_match_finder_defines.svh */
// Assertion macros for the first substring match finder.
// Included by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef FIRST_SUBSTRING_MATCH_FINDER_DEFINES_SVH
`define FIRST_SUBSTRING_MATCH_FINDER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside reset.
`define FSMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("first_substring_match_finder: assertion failed");
// The condition must never be true outside reset.
`define FSMF_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("first_substring_match_finder: forbidden condition seen");
`else
`define FSMF_ASSERT(lbl, prop)
`define FSMF_ASSERT_NEVER(lbl, cond)
`endif
`endif

/* rtl/core/fsmf_pkg.sv */
// Shared types and constants of the first substring match finder.
// No dependencies; every other file of the block uses it, apart from the macro header.
`timescale 1ns / 1ps
`default_nettype none

package fsmf_pkg;

  // Default sizes of the pattern window and of the searched text.
  localparam int PatternMaxDefault = 16;
  localparam int TextMaxDefault    = 4096;

  // Fixed field widths.
  localparam int ByteW    = 8;
  localparam int LenW     = 5;
  localparam int PosW     = 12;
  localparam int PatternW = 128;
  localparam int DataW    = 64;
  localparam int PaddrW   = 5;
  localparam int RegIdxW  = 2;

  // Register indexes, taken from paddr[4:3].
  localparam logic [RegIdxW-1:0] RegPatternLow    = 2'd0;
  localparam logic [RegIdxW-1:0] RegPatternHigh   = 2'd1;
  localparam logic [RegIdxW-1:0] RegPatternLength = 2'd2;

  // Reset value of the pattern length register.
  localparam logic [LenW-1:0] LengthReset = 5'd1;

  // Configuration handed from the register file to the datapath.
  typedef struct packed {
    logic [PatternW-1:0] pattern;
    logic [LenW-1:0]     length;
  } fsmf_cfg_t;

  // Per-cycle control of the window cells.
  typedef struct packed {
    logic shift;
    logic clear;
  } fsmf_cell_ctrl_t;

  // One result item.
  typedef struct packed {
    logic            found;
    logic [PosW-1:0] match_position;
    logic            too_long;
  } fsmf_result_t;

endpackage

`default_nettype wire

/* rtl/core/fsmf_text_if.sv */
// Text input channel: one text byte per item with a last-byte mark.
// Depends on fsmf_pkg for the byte width.
`timescale 1ns / 1ps
`default_nettype none

interface fsmf_text_if;
  import fsmf_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/fsmf_result_if.sv */
// Result output channel: found flag, first match position, overflow flag.
// Depends on fsmf_pkg for the position width.
`timescale 1ns / 1ps
`default_nettype none

interface fsmf_result_if;
  import fsmf_pkg::*;

  logic            valid;
  logic            ready;
  logic            found;
  logic [PosW-1:0] match_position;
  logic            too_long;

  modport source (output valid, output found, output match_position, output too_long,
                  input ready);
  modport sink (input valid, input found, input match_position, input too_long,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/fsmf_cell.sv */
// One window cell: holds one recent text byte, passes it on when the
// window shifts and extends the running pattern comparison. Uses fsmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsmf_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire fsmf_pkg::fsmf_cell_ctrl_t ctrl_i,
  input  wire logic [fsmf_pkg::ByteW-1:0] byte_i,
  input  wire logic [fsmf_pkg::ByteW-1:0] expect_i,
  input  wire logic                     active_i,
  input  wire logic                     match_i,
  output logic [fsmf_pkg::ByteW-1:0]    byte_o,
  output logic                          match_o
);
  import fsmf_pkg::*;

  logic [ByteW-1:0] byte_q;
  logic [ByteW-1:0] byte_d;

  // The comparison looks at the window after this shift, so it uses the byte
  // arriving from the neighbor. Cells beyond the pattern length always agree.
  assign match_o = match_i & (~active_i | (byte_i == expect_i));

  // Shift in the neighbor's byte; the end of a text empties the window.
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = '0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

/* rtl/core/fsmf_regs.sv */
// Configuration registers behind an APB-style port: two 64-bit pattern
// halves and the pattern length. Uses fsmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsmf_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fsmf_pkg::PaddrW-1:0]  paddr,
  input  wire logic [fsmf_pkg::DataW-1:0]   pwdata,
  output logic      [fsmf_pkg::DataW-1:0]   prdata,
  output logic                              pready,
  output fsmf_pkg::fsmf_cfg_t               cfg_o
);
  import fsmf_pkg::*;

  logic [DataW-1:0]   low_q, low_d;
  logic [DataW-1:0]   high_q, high_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrW-1:3];
  assign wr_en   = psel & penable & pwrite;

  // Register write decode.
  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    len_d  = len_q;
    if (wr_en) begin
      case (reg_idx)
        RegPatternLow: begin
          low_d = pwdata;
        end
        RegPatternHigh: begin
          high_d = pwdata;
        end
        RegPatternLength: begin
          len_d = pwdata[LenW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '0;
      len_q  <= LengthReset;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
      len_q  <= len_d;
    end
  end

  // Read data mux.
  always_comb begin
    case (reg_idx)
      RegPatternLow:    prdata = low_q;
      RegPatternHigh:   prdata = high_q;
      RegPatternLength: prdata = DataW'(len_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.pattern = {high_q, low_q};
  assign cfg_o.length  = len_q;

endmodule

`default_nettype wire

/* rtl/core/first_substring_match_finder.sv */
// Top level of the first substring match finder: register file, a row of
// window cells and the result buffer. Uses fsmf_pkg, the two channel
// interfaces, fsmf_cell, fsmf_regs and the assertion macro header.
//
// Usage: program the pattern (bytes 0..15 over two 64-bit registers at 0x0
// and 0x8) and its length (0x10) through the APB port while the block is
// idle. Then stream text on text_i, one byte per item, and mark the final
// byte with last_byte. Each text yields exactly one item on result_o: found,
// the zero-based start of the earliest full match (0 when none) and
// too_long, set when the text ran past TEXT_MAX bytes; later bytes are not
// searched. A match that ends on the last byte counts.
// Throughput is one text byte per cycle while text_i.ready is high: each byte
// shifts through the row of PATTERN_MAX cells, whose comparison chain is
// evaluated in the same cycle. A result is registered when its last byte is taken.
// A two-entry result buffer lets text keep flowing while a result waits;
// text_i.ready is low while both entries are occupied, which happens only
// after result_o has stalled. Reset empties the window, counters and result
// buffer and loads the register reset values (pattern zero, length one).
// After each text the search state clears; the registers keep their values.
`timescale 1ns / 1ps
`default_nettype none
`include "first_substring_match_finder_defines.svh"

module first_substring_match_finder #(
  parameter int PATTERN_MAX = fsmf_pkg::PatternMaxDefault,
  parameter int TEXT_MAX    = fsmf_pkg::TextMaxDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fsmf_pkg::PaddrW-1:0] paddr,
  input  wire logic [fsmf_pkg::DataW-1:0]  pwdata,
  output logic      [fsmf_pkg::DataW-1:0]  prdata,
  output logic                             pready,
  fsmf_text_if.sink                        text_i,
  fsmf_result_if.source                    result_o
);
  import fsmf_pkg::*;

  localparam int CountW = $clog2(TEXT_MAX + 1);
  localparam int ExtW   = (CountW > PosW) ? CountW : PosW;

  fsmf_cfg_t       cfg;
  fsmf_cell_ctrl_t cell_ctrl;
  logic [LenW-1:0] n_eff;

  logic [ByteW-1:0] chain_byte [PATTERN_MAX+1];
  logic             chain_match [PATTERN_MAX+1];

  logic              in_acc, in_last, searching, window_hit, hit_now;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_inc, start;
  logic [ExtW-1:0]   start_ext;
  logic              match_seen_q, match_seen_d;
  logic [PosW-1:0]   first_q, first_d;
  logic              ovf_q, ovf_d;

  fsmf_result_t res;
  fsmf_result_t out_q, out_d, skid_q, skid_d;
  logic         out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic         push, pop;

  // Configuration registers.
  fsmf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Effective pattern length: zero counts as one, long values saturate.
  always_comb begin
    n_eff = cfg.length;
    if (cfg.length == '0) begin
      n_eff = LenW'(1);
    end else if (cfg.length > LenW'(PATTERN_MAX)) begin
      n_eff = LenW'(PATTERN_MAX);
    end
  end

  assign in_acc    = text_i.valid & text_i.ready;
  assign in_last   = text_i.last_byte;
  assign searching = (cnt_q < CountW'(TEXT_MAX));
  assign cnt_inc   = cnt_q + CountW'(1);

  assign cell_ctrl.shift = in_acc & searching;
  assign cell_ctrl.clear = in_acc & in_last;

  assign chain_byte[0]  = text_i.text_byte;
  assign chain_match[0] = 1'b1;

  // Row of window cells. Cell j holds the j-th newest byte and checks it
  // against pattern byte n-1-j while j is inside the pattern.
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic [LenW-1:0]  idx;
    logic [ByteW-1:0] expect_byte;
    logic             active;

    assign active      = (LenW'(j) < n_eff);
    assign idx         = n_eff - LenW'(1) - LenW'(j);
    assign expect_byte = cfg.pattern[{idx[3:0], 3'b000} +: ByteW];

    fsmf_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .byte_i   (chain_byte[j]),
      .expect_i (expect_byte),
      .active_i (active),
      .match_i  (chain_match[j]),
      .byte_o   (chain_byte[j+1]),
      .match_o  (chain_match[j+1])
    );
  end

  assign window_hit = chain_match[PATTERN_MAX];
  assign hit_now    = cell_ctrl.shift & ~match_seen_q
                    & (cnt_inc >= CountW'(n_eff)) & window_hit;
  assign start      = cnt_inc - CountW'(n_eff);
  assign start_ext  = ExtW'(start);

  // Result of the text that ends with this item.
  always_comb begin
    res.found          = match_seen_q | hit_now;
    res.match_position = match_seen_q ? first_q :
                         (hit_now ? start_ext[PosW-1:0] : '0);
    res.too_long       = ovf_q | (in_acc & ~searching);
  end

  // Search state: byte count, first match and overflow flag.
  always_comb begin
    cnt_d        = cnt_q;
    match_seen_d = match_seen_q;
    first_d      = first_q;
    ovf_d        = ovf_q;
    if (in_acc) begin
      if (in_last) begin
        cnt_d        = '0;
        match_seen_d = 1'b0;
        first_d      = '0;
        ovf_d        = 1'b0;
      end else begin
        if (searching) begin
          cnt_d = cnt_inc;
        end else begin
          ovf_d = 1'b1;
        end
        if (hit_now) begin
          match_seen_d = 1'b1;
          first_d      = start_ext[PosW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      match_seen_q <= 1'b0;
      first_q      <= '0;
      ovf_q        <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      match_seen_q <= match_seen_d;
      first_q      <= first_d;
      ovf_q        <= ovf_d;
    end
  end

  // Two-entry result buffer: output register plus skid entry.
  assign push = in_acc & in_last;
  assign pop  = out_valid_q & result_o.ready;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = push;
      end
    end else if (push) begin
      if (!out_valid_q) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign text_i.ready            = ~skid_valid_q;
  assign result_o.valid          = out_valid_q;
  assign result_o.found          = out_q.found;
  assign result_o.match_position = out_q.match_position;
  assign result_o.too_long       = out_q.too_long;

  // The skid entry is only ever filled behind a waiting output entry.
  `FSMF_ASSERT_NEVER(a_skid_behind_out, skid_valid_q && !out_valid_q)
  // A text without a match reports position zero.
  `FSMF_ASSERT_NEVER(a_nomatch_pos_zero, out_valid_q && !out_q.found && (out_q.match_position != '0))
  // The end of a text leaves the search state cleared.
  `FSMF_ASSERT(a_clear_after_last, in_acc && in_last |=> (cnt_q == '0) && !match_seen_q && !ovf_q)
  // A full window match before the end of the text is remembered.
  `FSMF_ASSERT(a_hit_kept, in_acc && hit_now && !in_last |=> match_seen_q)

endmodule

`default_nettype wire

/* bench/first_substring_match_finder_tb.sv */
// Self-checking testbench of the first substring match finder: directed and random texts
// stream in under random idling, and every report is checked against a predictor.
// Depends on fsmf_pkg, fsmf_text_if, fsmf_result_if and the first_substring_match_finder top.
`timescale 1ns / 1ps

module first_substring_match_finder_tb;
  import fsmf_pkg::*;

  localparam int WindowSlots  = PatternMaxDefault;
  localparam int TextLimit    = TextMaxDefault;
  localparam int RandomBytes  = 700;
  localparam int HoldCycles   = 200;
  localparam int SettleCycles = 4;
  localparam int StallLimit   = 2000;
  localparam int ReportLimit  = 10;

  // Predicts the search and holds the reports still owed by the block.
  class search_scoreboard;
    logic [DataW-1:0] pattern_lo;
    logic [DataW-1:0] pattern_hi;
    logic [LenW-1:0]  pattern_len;
    logic [ByteW-1:0] recent [WindowSlots];
    int unsigned      bytes_taken;
    bit               hit_seen;
    logic [PosW-1:0]  hit_start;
    bit               overran;
    fsmf_result_t     expected_reports [$];
    int               faults;

    function new();
      pattern_lo  = '0;
      pattern_hi  = '0;
      pattern_len = LengthReset;
      faults      = 0;
      clear_search();
    endfunction

    function void clear_search();
      foreach (recent[i]) recent[i] = '0;
      bytes_taken = 0;
      hit_seen    = 1'b0;
      hit_start   = '0;
      overran     = 1'b0;
    endfunction

    function void write_register(logic [RegIdxW-1:0] idx, logic [DataW-1:0] value);
      case (idx)
        RegPatternLow:    pattern_lo = value;
        RegPatternHigh:   pattern_hi = value;
        RegPatternLength: pattern_len = value[LenW-1:0];
        default: ;
      endcase
    endfunction

    function logic [ByteW-1:0] pattern_byte(int k);
      logic [PatternW-1:0] full;
      full = {pattern_hi, pattern_lo};
      return full[ByteW*k +: ByteW];
    endfunction

    // A length of zero searches for one byte; lengths past the window saturate.
    function int active_length();
      if (pattern_len == 0) return 1;
      if (pattern_len > WindowSlots) return WindowSlots;
      return int'(pattern_len);
    endfunction

    // The oldest of the last n bytes lines up with pattern byte 0.
    function bit window_hits(int n);
      int k;
      for (k = 0; k < n; k++) begin
        if (recent[n - 1 - k] != pattern_byte(k)) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Takes one accepted text byte; the last one of a text owes a report.
    function void note_byte(logic [ByteW-1:0] value, logic is_last);
      fsmf_result_t rep;
      int n;
      int i;
      if (bytes_taken < TextLimit) begin
        n = active_length();
        for (i = WindowSlots - 1; i > 0; i--) recent[i] = recent[i - 1];
        recent[0] = value;
        bytes_taken++;
        if (!hit_seen && bytes_taken >= n && window_hits(n)) begin
          hit_seen  = 1'b1;
          hit_start = PosW'(bytes_taken - n);
        end
      end else begin
        overran = 1'b1;
      end
      if (is_last) begin
        rep.found          = hit_seen;
        rep.match_position = hit_seen ? hit_start : '0;
        rep.too_long       = overran;
        expected_reports.push_back(rep);
        clear_search();
      end
    endfunction

    // Compares one report from the block with the oldest one owed.
    function void check_report(fsmf_result_t got);
      fsmf_result_t want;
      if (expected_reports.size() == 0) begin
        faults++;
        if (faults <= ReportLimit)
          $display("%0t: report with none owed: found=%0b position=%0d too_long=%0b",
                   $time, got.found, got.match_position, got.too_long);
        return;
      end
      want = expected_reports.pop_front();
      if (got.found !== want.found || got.match_position !== want.match_position ||
          got.too_long !== want.too_long) begin
        faults++;
        if (faults <= ReportLimit)
          $display("%0t: report mismatch: expected found=%0b position=%0d too_long=%0b, %s",
                   $time, want.found, want.match_position, want.too_long,
                   $sformatf("got found=%0b position=%0d too_long=%0b",
                             got.found, got.match_position, got.too_long));
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [PaddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  fsmf_text_if   text_if ();
  fsmf_result_if result_if ();

  search_scoreboard sb = new();

  logic [ByteW-1:0] text_buf [$];
  int               burst_left    = 0;
  int               random_bytes  = 0;
  logic [ByteW-1:0] sym_a         = '0;
  logic [ByteW-1:0] sym_b         = '0;
  bit               narrow_alphabet = 1'b0;

  // Receiver state: stall mode, its remaining stretch and long hold-off requests.
  int   hold_requests = 0;
  int   holds_granted = 0;
  int   hold_left     = 0;
  int   segment_left  = 0;
  int   stall_mode    = 0;
  logic ready_next;
  int   idle_cycles   = 0;

  first_substring_match_finder u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .text_i   (text_if.sink),
    .result_o (result_if.source)
  );

  always #2 clk_i = ~clk_i;

  // Both channels are sampled at the rising edge; text first, then results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (text_if.valid && text_if.ready)
        sb.note_byte(text_if.text_byte, text_if.last_byte);
      if (result_if.valid && result_if.ready)
        sb.check_report(fsmf_result_t'({result_if.found, result_if.match_position,
                                        result_if.too_long}));
    end
  end

  // Receiver: a long hold-off when asked, otherwise stretches of varying stall modes.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else if (holds_granted != hold_requests) begin
      holds_granted++;
      hold_left  = HoldCycles;
      ready_next = 1'b0;
    end else begin
      if (segment_left == 0) begin
        stall_mode   = $urandom_range(0, 3);
        segment_left = $urandom_range(4, 60);
      end
      segment_left--;
      case (stall_mode)
        0:       ready_next = 1'b1;
        1:       ready_next = $urandom_range(0, 1);
        2:       ready_next = ($urandom_range(0, 3) == 0);
        default: ready_next = ((segment_left % 3) == 0);
      endcase
    end
    result_if.ready <= ready_next;
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((text_if.valid && text_if.ready) || (result_if.valid && result_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // APB write: setup phase, then access phase until pready.
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 3'b000});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offers one byte, with a random gap whenever a burst runs out.
  task automatic send_byte(input logic [ByteW-1:0] value, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        text_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    text_if.valid     <= 1'b1;
    text_if.text_byte <= value;
    text_if.last_byte <= is_last;
    do @(posedge clk_i); while (!text_if.ready);
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  // Stops offering text until every owed report has come, then lets the block settle.
  task automatic wait_for_reports();
    text_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Random text, optionally with a full or a broken copy of the pattern planted.
  task automatic build_text(input int len, input bit plant);
    int i;
    int n;
    int at;
    int keep;
    text_buf = {};
    for (i = 0; i < len; i++)
      text_buf.push_back(narrow_alphabet ? ($urandom_range(0, 1) ? sym_a : sym_b)
                                         : ByteW'($urandom));
    if (plant) begin
      n    = sb.active_length();
      keep = ($urandom_range(0, 4) == 0) ? n - 1 : n;
      if (len <= n || $urandom_range(0, 2) == 0)
        at = (len > n) ? len - n : 0;
      else
        at = $urandom_range(0, len - n);
      for (i = 0; i < keep && at + i < len; i++) text_buf[at + i] = sb.pattern_byte(i);
    end
  endtask

  // New pattern and alphabet for a phase; short lengths dominate so matches occur.
  task automatic pick_pattern();
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
    logic [LenW-1:0]  len;
    int               i;
    int               roll;
    sym_a           = $urandom;
    sym_b           = $urandom;
    narrow_alphabet = ($urandom_range(0, 2) != 0);
    if (narrow_alphabet) begin
      for (i = 0; i < 8; i++) begin
        lo[8*i +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
        hi[8*i +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
      end
    end else begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
    end
    roll = $urandom_range(0, 99);
    if (roll < 65)      len = LenW'($urandom_range(1, 4));
    else if (roll < 90) len = LenW'($urandom_range(5, 16));
    else                len = LenW'($urandom_range(0, 31));
    write_reg(RegPatternLength, DataW'(len));
    write_reg(RegPatternLow, lo);
    write_reg(RegPatternHigh, hi);
  endtask

  initial begin
    int  phase;
    int  texts;
    int  len;
    bit  hold_phase;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    text_if.valid     = 1'b0;
    text_if.text_byte = '0;
    text_if.last_byte = 1'b0;
    result_if.ready   = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset pattern is one zero byte; zero is an ordinary byte, also on the final byte.
    text_buf = {8'h00};
    send_text();
    text_buf = {8'h41, 8'h00};
    send_text();
    wait_for_reports();

    // Three-byte pattern ending on the final byte.
    write_reg(RegPatternLow, 64'h0000_0000_0063_6261);
    write_reg(RegPatternLength, 64'd3);
    text_buf = {8'h7a, 8'h61, 8'h62, 8'h63};
    send_text();
    wait_for_reports();

    // Length zero acts as length one.
    write_reg(RegPatternLength, 64'd0);
    text_buf = {8'h78, 8'h61};
    send_text();
    wait_for_reports();

    // All-ones pattern with an oversized length saturates to the full window.
    write_reg(RegPatternLow, '1);
    write_reg(RegPatternHigh, '1);
    write_reg(RegPatternLength, 64'd31);
    text_buf = {};
    repeat (16) text_buf.push_back(8'hFF);
    send_text();
    wait_for_reports();

    // Pattern changed in the middle of a text: the window is kept.
    write_reg(RegPatternLow, 64'h33);
    write_reg(RegPatternLength, 64'd1);
    send_byte(8'h20, 1'b0);
    wait_for_reports();
    write_reg(RegPatternLow, 64'h5520);
    write_reg(RegPatternLength, 64'd2);
    send_byte(8'h55, 1'b1);
    wait_for_reports();

    // Random phases; some of them run short texts against a long receiver hold-off.
    phase = 0;
    while (random_bytes < RandomBytes) begin
      wait_for_reports();
      pick_pattern();
      hold_phase = ((phase % 7) == 2);
      if (hold_phase) hold_requests <= hold_requests + 1;
      texts = hold_phase ? $urandom_range(12, 20) : $urandom_range(3, 12);
      repeat (texts) begin
        if (hold_phase)                     len = $urandom_range(1, 3);
        else if ($urandom_range(0, 3) == 0) len = $urandom_range(1, 40);
        else                                len = $urandom_range(1, 16);
        build_text(len, $urandom_range(0, 4) != 0);
        send_text();
        random_bytes += len;
      end
      phase++;
    end

    wait_for_reports();
    if (sb.faults == 0 && sb.expected_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
